// ===== sv/smdp_pkg.sv =====
`default_nettype none
package smdp_pkg;

  // fixed widths of the datapath
  localparam int unsigned REQ_W    = 8;
  localparam int unsigned SUPPLY_W = 15;
  localparam int unsigned LIMIT_W  = 15;
  localparam int unsigned STEP_W   = 11;
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned DUTY_W   = 11;
  localparam int unsigned MAG_W    = 11;
  localparam int unsigned DIV_W    = 26;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned SLEW_W   = 14;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(7400);
  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(10);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_CAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP  = 1'b1;

  typedef struct packed {
    logic signed [REQ_W-1:0] left_request;
    logic signed [REQ_W-1:0] right_request;
    logic [SUPPLY_W-1:0]     supply_mv;
  } smdp_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]         left_forward_duty;
    logic [DUTY_W-1:0]         left_reverse_duty;
    logic [DUTY_W-1:0]         right_forward_duty;
    logic [DUTY_W-1:0]         right_reverse_duty;
    logic signed [LEVEL_W-1:0] left_drive_level;
    logic signed [LEVEL_W-1:0] right_drive_level;
  } smdp_out_t;

  typedef struct packed {
    logic                      idle;
    logic                      done;
    logic signed [LEVEL_W-1:0] level;
  } smdp_lane_status_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_MUL,
    LN_LOAD,
    LN_DIV,
    LN_DONE
  } smdp_lane_state_e;

  typedef struct packed {
    logic [DUTY_W-1:0] fwd;
    logic [DUTY_W-1:0] rev;
  } smdp_duty_t;

  // positive level drives forward, otherwise reverse with the magnitude
  function automatic smdp_duty_t drive_duty(input logic signed [LEVEL_W-1:0] level);
    smdp_duty_t d;
    logic [LEVEL_W-1:0] neg;
    neg = -level;
    if (level > 0) begin
      d.fwd = level[DUTY_W-1:0];
      d.rev = '0;
    end else begin
      d.fwd = '0;
      d.rev = neg[DUTY_W-1:0];
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== sv/slew_limited_dual_motor_pwm_unit.sv =====
// Slew-limited dual H-bridge drive.
// Input channel (in_valid_i / in_stall_o / in_word_i) takes one control tick:
// left and right signed speed requests and the supply in millivolts.
// Output channel (out_valid_o / out_stall_i / out_word_o) returns one word per
// tick: the four H-bridge duties and the two new signed drive levels.
// Two lanes, one per motor, each scale and slew their own level; the output
// stage merges both into one word.
// A tick runs through the lane states MUL, then LOAD and DIV when the supply is
// above the supply cap, then DONE; DIV is the 26-step restoring divider in each
// lane (one quotient bit per cycle). The output word is registered on release.
// A new tick is taken as soon as the lanes are idle, even while the previous
// word still waits at the output.
// When the receiver stalls, the finished lanes hold their result and the
// output word stays put until it is taken.
// Reset clears both levels to zero and loads supply cap 7400, slew_step 10.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 supply cap, 1 slew_step); user-enforced: only while no tick is in flight.
`default_nettype none
module slew_limited_dual_motor_pwm_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [smdp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [smdp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire smdp_pkg::smdp_in_t                 in_word_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output smdp_pkg::smdp_out_t                     out_word_o
);

  logic [smdp_pkg::LIMIT_W-1:0] limit_q;
  logic [smdp_pkg::STEP_W-1:0]  step_q;
  logic                         out_valid_q, out_valid_d;
  smdp_pkg::smdp_out_t          out_q;

  smdp_pkg::smdp_lane_status_t  left_st, right_st;
  smdp_pkg::smdp_duty_t         left_duty, right_duty;
  logic                         start;
  logic                         release_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= smdp_pkg::LIMIT_RESET;
      step_q  <= smdp_pkg::STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        smdp_pkg::CFG_SUPPLY_CAP: limit_q <= cfg_data_i[smdp_pkg::LIMIT_W-1:0];
        smdp_pkg::CFG_SLEW_STEP:  step_q  <= cfg_data_i[smdp_pkg::STEP_W-1:0];
        default: begin
          limit_q <= limit_q;
        end
      endcase
    end
  end

  assign in_stall_o = !(left_st.idle && right_st.idle);
  assign start      = in_valid_i && !in_stall_o;

  // both lanes finish together; hand over when the output register is free
  assign release_w = left_st.done && right_st.done && (!out_valid_q || !out_stall_i);

  smdp_lane u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .release_i (release_w),
    .request_i (in_word_i.left_request),
    .supply_i  (in_word_i.supply_mv),
    .limit_i   (limit_q),
    .step_i    (step_q),
    .status_o  (left_st)
  );

  smdp_lane u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .release_i (release_w),
    .request_i (in_word_i.right_request),
    .supply_i  (in_word_i.supply_mv),
    .limit_i   (limit_q),
    .step_i    (step_q),
    .status_o  (right_st)
  );

  assign left_duty  = smdp_pkg::drive_duty(left_st.level);
  assign right_duty = smdp_pkg::drive_duty(right_st.level);

  always_comb begin
    out_valid_d = out_valid_q;
    if (release_w) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (release_w) begin
      out_q.left_forward_duty  <= left_duty.fwd;
      out_q.left_reverse_duty  <= left_duty.rev;
      out_q.right_forward_duty <= right_duty.fwd;
      out_q.right_reverse_duty <= right_duty.rev;
      out_q.left_drive_level   <= left_st.level;
      out_q.right_drive_level  <= right_st.level;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire

// ===== sv/smdp_div.sv =====
`default_nettype none
module smdp_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [smdp_pkg::DIV_W-1:0]      dividend_i,
  input  wire logic [smdp_pkg::SUPPLY_W-1:0]   divisor_i,
  output logic                                 done_o,
  output logic [smdp_pkg::DIV_W-1:0]           quotient_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [smdp_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [smdp_pkg::SUPPLY_W-1:0]     rem_q, rem_d;
  logic [smdp_pkg::DIV_W-1:0]        quo_q, quo_d;
  logic [smdp_pkg::SUPPLY_W-1:0]     dvs_q, dvs_d;
  logic [smdp_pkg::SUPPLY_W:0]       shifted;
  logic [smdp_pkg::SUPPLY_W:0]       reduced;
  logic                              ge;

  // one restoring step per cycle, dividend bits shift out as quotient bits shift in
  assign shifted = {rem_q, quo_q[smdp_pkg::DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign reduced = ge ? (shifted - {1'b0, dvs_q}) : shifted;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = smdp_pkg::CNT_W'(smdp_pkg::DIV_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = reduced[smdp_pkg::SUPPLY_W-1:0];
      quo_d = {quo_q[smdp_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == smdp_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== sv/smdp_lane.sv =====
`default_nettype none
module smdp_lane (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic                                release_i,
  input  wire logic signed [smdp_pkg::REQ_W-1:0]   request_i,
  input  wire logic [smdp_pkg::SUPPLY_W-1:0]       supply_i,
  input  wire logic [smdp_pkg::LIMIT_W-1:0]        limit_i,
  input  wire logic [smdp_pkg::STEP_W-1:0]         step_i,
  output smdp_pkg::smdp_lane_status_t              status_o
);

  smdp_pkg::smdp_lane_state_e state_q, state_d;

  logic signed [smdp_pkg::LEVEL_W-1:0] level_q, level_d;
  logic signed [smdp_pkg::LEVEL_W-1:0] target_q;
  logic signed [smdp_pkg::LEVEL_W-1:0] quot_q;
  logic [smdp_pkg::SUPPLY_W-1:0]       supply_q;
  logic                                scale_q;
  logic [smdp_pkg::DIV_W-1:0]          mag_q;
  logic                                neg_q;

  logic signed [smdp_pkg::LEVEL_W-1:0] req_ext;
  logic signed [smdp_pkg::LEVEL_W-1:0] target;
  logic [smdp_pkg::LEVEL_W-1:0]        target_neg;
  logic [smdp_pkg::MAG_W-1:0]          target_mag;
  logic [smdp_pkg::DIV_W-1:0]          product;
  logic                                div_start;
  logic                                div_done;
  logic [smdp_pkg::DIV_W-1:0]          div_quo;
  logic [smdp_pkg::LEVEL_W-1:0]        quo_mag;
  logic signed [smdp_pkg::SLEW_W-1:0]  cur_w, tgt_w, step_w, up_w, dn_w, new_w;

  // request times ten as two shifts and an add
  assign req_ext = smdp_pkg::LEVEL_W'(request_i);
  assign target  = (req_ext <<< 3) + (req_ext <<< 1);

  assign target_neg = -target_q;
  assign target_mag = target_q[smdp_pkg::LEVEL_W-1] ? target_neg[smdp_pkg::MAG_W-1:0]
                                                     : target_q[smdp_pkg::MAG_W-1:0];
  assign product = {{(smdp_pkg::DIV_W-smdp_pkg::MAG_W){1'b0}}, target_mag}
                 * {{(smdp_pkg::DIV_W-smdp_pkg::LIMIT_W){1'b0}}, limit_i};

  assign quo_mag = div_quo[smdp_pkg::LEVEL_W-1:0];

  smdp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_q),
    .divisor_i  (supply_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // slew limit toward the final target
  assign cur_w  = smdp_pkg::SLEW_W'(level_q);
  assign tgt_w  = smdp_pkg::SLEW_W'(quot_q);
  assign step_w = signed'({{(smdp_pkg::SLEW_W-smdp_pkg::STEP_W){1'b0}}, step_i});
  assign up_w   = cur_w + step_w;
  assign dn_w   = cur_w - step_w;

  always_comb begin
    if (tgt_w > up_w) begin
      new_w = up_w;
    end else if (tgt_w < dn_w) begin
      new_w = dn_w;
    end else begin
      new_w = tgt_w;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      smdp_pkg::LN_IDLE: begin
        if (start_i) state_d = smdp_pkg::LN_MUL;
      end
      smdp_pkg::LN_MUL: begin
        state_d = scale_q ? smdp_pkg::LN_LOAD : smdp_pkg::LN_DONE;
      end
      smdp_pkg::LN_LOAD: begin
        state_d = smdp_pkg::LN_DIV;
      end
      smdp_pkg::LN_DIV: begin
        if (div_done) state_d = smdp_pkg::LN_DONE;
      end
      smdp_pkg::LN_DONE: begin
        if (release_i) state_d = smdp_pkg::LN_IDLE;
      end
      default: begin
        state_d = smdp_pkg::LN_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    div_start      = 1'b0;
    status_o.idle  = 1'b0;
    status_o.done  = 1'b0;
    status_o.level = new_w[smdp_pkg::LEVEL_W-1:0];
    level_d        = level_q;
    case (state_q)
      smdp_pkg::LN_IDLE: begin
        status_o.idle = 1'b1;
      end
      smdp_pkg::LN_LOAD: begin
        div_start = 1'b1;
      end
      smdp_pkg::LN_DONE: begin
        status_o.done = 1'b1;
        if (release_i) level_d = new_w[smdp_pkg::LEVEL_W-1:0];
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smdp_pkg::LN_IDLE;
      level_q <= '0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == smdp_pkg::LN_IDLE && start_i) begin
      target_q <= target;
      supply_q <= supply_i;
      scale_q  <= supply_i > limit_i;
    end
    if (state_q == smdp_pkg::LN_MUL) begin
      mag_q <= product;
      neg_q <= target_q[smdp_pkg::LEVEL_W-1];
      if (!scale_q) quot_q <= target_q;
    end
    // quotient truncates toward zero: divide magnitudes, then restore sign
    if (state_q == smdp_pkg::LN_DIV && div_done) begin
      quot_q <= neg_q ? -signed'(quo_mag) : signed'(quo_mag);
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smdp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_WORDS = 115;
  localparam int unsigned DRAIN       = 40;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    smdp_in_t              word;
    logic                  typed;
    smdp_out_t             want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_SUPPLY_CAP;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  smdp_in_t              in_word    = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  smdp_out_t             out_word;

  slew_limited_dual_motor_pwm_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  // predictor copy of registers and motor levels
  int limit_mv   = 7400;
  int step_size  = 10;
  int left_lvl   = 0;
  int right_lvl  = 0;

  smdp_out_t   pending_words[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  bit          idle_on    = 1'b1;
  int          stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int slew_toward(int cur, int req, int sup);
    int target;
    target = req * 10;
    if (sup > limit_mv) target = (target * limit_mv) / sup;
    if (target > cur + step_size) return cur + step_size;
    if (target < cur - step_size) return cur - step_size;
    return target;
  endfunction

  function automatic smdp_out_t advance_levels(smdp_in_t w);
    smdp_out_t o;
    left_lvl  = slew_toward(left_lvl, int'(w.left_request), int'(w.supply_mv));
    right_lvl = slew_toward(right_lvl, int'(w.right_request), int'(w.supply_mv));
    o.left_forward_duty  = (left_lvl > 0) ? DUTY_W'(left_lvl) : '0;
    o.left_reverse_duty  = (left_lvl > 0) ? '0 : DUTY_W'(-left_lvl);
    o.right_forward_duty = (right_lvl > 0) ? DUTY_W'(right_lvl) : '0;
    o.right_reverse_duty = (right_lvl > 0) ? '0 : DUTY_W'(-right_lvl);
    o.left_drive_level   = LEVEL_W'(left_lvl);
    o.right_drive_level  = LEVEL_W'(right_lvl);
    return o;
  endfunction

  task automatic field_check(string name, logic signed [15:0] want, logic signed [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d got %0d", name, want, got);
    end
  endtask

  task automatic check_word(smdp_out_t want, smdp_out_t got);
    field_check("left_forward_duty", want.left_forward_duty, got.left_forward_duty);
    field_check("left_reverse_duty", want.left_reverse_duty, got.left_reverse_duty);
    field_check("right_forward_duty", want.right_forward_duty, got.right_forward_duty);
    field_check("right_reverse_duty", want.right_reverse_duty, got.right_reverse_duty);
    field_check("left_drive_level", want.left_drive_level, got.left_drive_level);
    field_check("right_drive_level", want.right_drive_level, got.right_drive_level);
  endtask

  // random receiver stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_word);
      end else begin
        check_word(pending_words.pop_front(), out_word);
      end
    end
  end

  task automatic send_tick(smdp_in_t w, logic typed, smdp_out_t want);
    smdp_out_t predicted;
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    predicted = advance_levels(w);
    pending_words.push_back(typed ? want : predicted);
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk) in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk) cfg_we <= 1'b0;
    if (idx == CFG_SUPPLY_CAP) limit_mv = int'(data);
    else step_size = int'(data[STEP_W-1:0]);
  endtask

  function automatic plan_row_t tick_row(int l, int r, int s);
    plan_row_t p;
    p = '0;
    p.word.left_request  = REQ_W'(l);
    p.word.right_request = REQ_W'(r);
    p.word.supply_mv     = SUPPLY_W'(s);
    return p;
  endfunction

  function automatic plan_row_t want_row(int l, int r, int s, int lf, int lr, int rf, int rr,
                                         int ll, int rl);
    plan_row_t p;
    p = tick_row(l, r, s);
    p.typed = 1'b1;
    p.want.left_forward_duty  = DUTY_W'(lf);
    p.want.left_reverse_duty  = DUTY_W'(lr);
    p.want.right_forward_duty = DUTY_W'(rf);
    p.want.right_reverse_duty = DUTY_W'(rr);
    p.want.left_drive_level   = LEVEL_W'(ll);
    p.want.right_drive_level  = LEVEL_W'(rl);
    return p;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int data);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.idx    = idx;
    p.data   = CFG_DATA_W'(data);
    return p;
  endfunction

  task automatic random_phase(int n);
    smdp_in_t w;
    int s;
    w = '0;
    for (int i = 0; i < n; i++) begin
      // hold requests for a while so levels can reach their targets
      if (i == 0 || $urandom_range(0, 3) == 0) begin
        w.left_request  = REQ_W'($urandom);
        w.right_request = REQ_W'($urandom);
        if ($urandom_range(0, 2) == 0)
          w.left_request = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
        if ($urandom_range(0, 2) == 0)
          w.right_request = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
      end
      case ($urandom_range(0, 5))
        0: s = 0;
        1: s = $urandom_range(0, 32767);
        2: s = limit_mv;
        3: s = (limit_mv < 32767) ? limit_mv + 1 : 32767;
        4: s = $urandom_range(limit_mv, 32767);
        default: s = $urandom_range(0, limit_mv);
      endcase
      w.supply_mv = SUPPLY_W'(s);
      send_tick(w, 1'b0, '0);
    end
  endtask

  initial begin
    plan_row_t plan[];
    int lim;
    int st;
    plan = '{
      want_row(127, -128, 0, 10, 0, 0, 10, 10, -10),
      want_row(0, 0, 7400, 0, 0, 0, 0, 0, 0),
      cfg_row(CFG_SLEW_STEP, 32767),
      want_row(127, -128, 7400, 1270, 0, 0, 1280, 1270, -1280),
      tick_row(127, -128, 32767),
      tick_row(-1, 1, 7401),
      cfg_row(CFG_SUPPLY_CAP, 0),
      want_row(127, -128, 1, 0, 0, 0, 0, 0, 0),
      tick_row(100, -100, 0),
      cfg_row(CFG_SUPPLY_CAP, 32767),
      tick_row(-128, 127, 32767),
      cfg_row(CFG_SLEW_STEP, 0),
      tick_row(127, -128, 100),
      cfg_row(CFG_SLEW_STEP, 1280),
      tick_row(127, -128, 0),
      tick_row(85, -86, 21845),
      tick_row(-86, 85, 10922),
      tick_row(-128, -128, 32767)
    };

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
      else send_tick(plan[i].word, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lim = 7400;  st = 10;   end
        1: begin lim = 1;     st = 1;    end
        2: begin lim = 32767; st = 2047; end
        3: begin lim = 0;     st = 1280; end
        4: begin lim = 7400;  st = 1280; end
        5: begin lim = 20000; st = 0;    end
        default: begin
          lim = $urandom_range(1, 32767);
          st  = $urandom_range(0, 1280);
        end
      endcase
      write_reg(CFG_SUPPLY_CAP, CFG_DATA_W'(lim));
      write_reg(CFG_SLEW_STEP, CFG_DATA_W'(st));
      if (p == PHASES - 1) idle_on = 1'b0;
      random_phase(PHASE_WORDS);
    end

    @(negedge clk) in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (pending_words.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== slew_limited_dual_motor_pwm_unit.f =====
sv/smdp_pkg.sv
sv/smdp_div.sv
sv/smdp_lane.sv
sv/slew_limited_dual_motor_pwm_unit.sv
tb/tb.sv
